// ===== hdl/sfps_pkg.sv =====
package sfps_pkg;

   localparam int PIXEL_W = 12;
   localparam int COLOR_W = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CHANNELS = 4;

   // Local coordinates and shape extents are handled as 19-bit signed values,
   // wide enough for pixel minus a signed 16-bit edge and for span minus size.
   localparam int COORD_W = 19;

   // Numerator of the gradient division: an 8-bit channel difference times
   // a 15-bit row.
   localparam int NUM_W = 23;

   localparam logic [1:0] MODE_ROUND    = 2'd0;
   localparam logic [1:0] MODE_OUTLINE  = 2'd1;
   localparam logic [1:0] MODE_GRADIENT = 2'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FILL_MODE    = 3'd0,
      REG_RECT_LEFT    = 3'd1,
      REG_RECT_TOP     = 3'd2,
      REG_RECT_SPAN_X  = 3'd3,
      REG_RECT_SPAN_Y  = 3'd4,
      REG_SHAPE_SIZE   = 3'd5,
      REG_FILL_COLOR   = 3'd6,
      REG_SECOND_COLOR = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [1:0]         fill_mode;
      logic signed [15:0] rect_left;
      logic signed [15:0] rect_top;
      logic [14:0]        rect_span_x;
      logic [14:0]        rect_span_y;
      logic [13:0]        shape_size;
      logic [31:0]        fill_color;
      logic [31:0]        second_color;
   } cfg_type;

   // Coverage flags of one pixel. Until the distance compare is done,
   // round_ok holds only the "outside every corner square" part.
   typedef struct packed {
      logic ok;
      logic in_rect;
      logic round_ok;
      logic outl;
   } shape_type;

   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [7:0]       quo;
   } div_type;

   typedef struct packed {
      div_type [CHANNELS-1:0] ch;
      logic [CHANNELS-1:0]    neg;
   } grad_type;

   // One restoring division step: try to take den shifted by sh from the
   // remainder and set quotient bit sh when it fits.
   function automatic div_type div_step(div_type d, logic [14:0] den, logic [2:0] sh);
      div_type r;
      logic [NUM_W-1:0] trial;
      r = d;
      trial = NUM_W'(den) << sh;
      if (d.rem >= trial) begin
         r.rem = d.rem - trial;
         r.quo[sh] = 1'b1;
      end
      return r;
   endfunction

endpackage

// ===== hdl/sfps_if.sv =====
interface sfps_req_if;
   logic                          valid;
   logic                          ready;
   logic [sfps_pkg::PIXEL_W-1:0]  pixel_x;
   logic [sfps_pkg::PIXEL_W-1:0]  pixel_y;
   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface sfps_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          covered;
   logic [sfps_pkg::COLOR_W-1:0]  pixel_color;
   modport source (output valid, output covered, output pixel_color, input ready);
   modport sink (input valid, input covered, input pixel_color, output ready);
endinterface

interface sfps_csr_if;
   logic                              valid;
   logic                              ready;
   logic [sfps_pkg::CSR_INDEX_W-1:0]  index;
   logic [sfps_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/sfps_cfg_regs.sv =====
module sfps_cfg_regs (
   input  logic              clock,
   input  logic              reset,
   sfps_csr_if.sink          csr_bus,
   output sfps_pkg::cfg_type cfg
);

   sfps_pkg::cfg_type cfg_ff;
   sfps_pkg::cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            sfps_pkg::REG_FILL_MODE:    cfg_in.fill_mode    = csr_bus.data[1:0];
            sfps_pkg::REG_RECT_LEFT:    cfg_in.rect_left    = $signed(csr_bus.data[15:0]);
            sfps_pkg::REG_RECT_TOP:     cfg_in.rect_top     = $signed(csr_bus.data[15:0]);
            sfps_pkg::REG_RECT_SPAN_X:  cfg_in.rect_span_x  = csr_bus.data[14:0];
            sfps_pkg::REG_RECT_SPAN_Y:  cfg_in.rect_span_y  = csr_bus.data[14:0];
            sfps_pkg::REG_SHAPE_SIZE:   cfg_in.shape_size   = csr_bus.data[13:0];
            sfps_pkg::REG_FILL_COLOR:   cfg_in.fill_color   = csr_bus.data;
            sfps_pkg::REG_SECOND_COLOR: cfg_in.second_color = csr_bus.data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/sfps_geom.sv =====
module sfps_geom (
   input  logic                          clock,
   input  sfps_pkg::cfg_type             cfg,
   input  logic [4:0]                    en,
   input  logic [sfps_pkg::PIXEL_W-1:0]  pixel_x,
   input  logic [sfps_pkg::PIXEL_W-1:0]  pixel_y,
   input  logic                          inframe,
   output logic [14:0]                   row,
   output sfps_pkg::shape_type           shape
);

   localparam int CW = sfps_pkg::COORD_W;

   // Stage A: pixel position relative to the shape's top left corner.
   logic signed [CW-1:0] lx_ff, lx_in, ly_ff, ly_in;
   logic                 inframe_ff;

   // Stage B: box tests and corner offsets.
   sfps_pkg::shape_type  b_flags_ff, b_flags_in;
   logic [13:0]          dxm_ff, dxm_in, dym_ff, dym_in;

   // Stage C: squares.
   sfps_pkg::shape_type  c_flags_ff;
   logic [27:0]          dx2_ff, dx2_in, dy2_ff, dy2_in, r2_ff, r2_in;

   // Stage D: distance compare folded into round_ok; stage E: hold.
   sfps_pkg::shape_type  d_flags_ff, d_flags_in, e_flags_ff;

   always_comb begin
      lx_in = $signed({{(CW-sfps_pkg::PIXEL_W){1'b0}}, pixel_x}) - CW'(cfg.rect_left);
      ly_in = $signed({{(CW-sfps_pkg::PIXEL_W){1'b0}}, pixel_y}) - CW'(cfg.rect_top);
   end

   always_comb begin
      logic signed [CW-1:0] w, h, r, dx, dy;
      logic x_in, y_in, lx_mid, ly_mid, bands;
      w = $signed({4'b0, cfg.rect_span_x});
      h = $signed({4'b0, cfg.rect_span_y});
      r = $signed({5'b0, cfg.shape_size});
      x_in = (lx_ff >= 0) && (lx_ff < w);
      y_in = (ly_ff >= 0) && (ly_ff < h);
      lx_mid = (lx_ff >= r) && (lx_ff < w - r);
      ly_mid = (ly_ff >= r) && (ly_ff < h - r);
      // Each outline band keeps its full thickness, even past the far edge.
      bands = (x_in && (ly_ff >= 0) && (ly_ff < r))
           || (x_in && (ly_ff >= h - r) && (ly_ff < h))
           || (y_in && (lx_ff >= 0) && (lx_ff < r))
           || (y_in && (lx_ff >= w - r) && (lx_ff < w));
      // Inside a corner square both offsets lie within one radius, so the
      // low bits carry the magnitude; elsewhere they are not used.
      dx = (lx_ff < r) ? (r - lx_ff) : (lx_ff - (w - r - CW'(1)));
      dy = (ly_ff < r) ? (r - ly_ff) : (ly_ff - (h - r - CW'(1)));
      b_flags_in.ok = inframe_ff && (cfg.rect_span_x != '0) && (cfg.rect_span_y != '0);
      b_flags_in.in_rect = x_in && y_in;
      b_flags_in.round_ok = lx_mid || ly_mid;
      b_flags_in.outl = (cfg.shape_size != '0) && bands;
      dxm_in = dx[13:0];
      dym_in = dy[13:0];
   end

   always_comb begin
      dx2_in = 28'(dxm_ff) * 28'(dxm_ff);
      dy2_in = 28'(dym_ff) * 28'(dym_ff);
      r2_in = 28'(cfg.shape_size) * 28'(cfg.shape_size);
   end

   always_comb begin
      d_flags_in = c_flags_ff;
      d_flags_in.round_ok = c_flags_ff.round_ok
                         || ((29'(dx2_ff) + 29'(dy2_ff)) <= 29'(r2_ff));
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         lx_ff <= lx_in;
         ly_ff <= ly_in;
         inframe_ff <= inframe;
      end
      if (en[1]) begin
         b_flags_ff <= b_flags_in;
         dxm_ff <= dxm_in;
         dym_ff <= dym_in;
      end
      if (en[2]) begin
         c_flags_ff <= b_flags_ff;
         dx2_ff <= dx2_in;
         dy2_ff <= dy2_in;
         r2_ff <= r2_in;
      end
      if (en[3]) begin
         d_flags_ff <= d_flags_in;
      end
      if (en[4]) begin
         e_flags_ff <= d_flags_ff;
      end
   end

   assign row = ly_ff[14:0];
   assign shape = e_flags_ff;

endmodule

// ===== hdl/sfps_div_stage.sv =====
module sfps_div_stage (
   input  logic               clock,
   input  logic               en,
   input  logic [2:0]         step_hi,
   input  logic [14:0]        den,
   input  sfps_pkg::grad_type grad_src,
   output sfps_pkg::grad_type grad_out
);

   sfps_pkg::grad_type grad_ff, grad_in;

   // Two quotient bits per stage, for all four channels side by side.
   always_comb begin
      grad_in = grad_src;
      for (int c = 0; c < sfps_pkg::CHANNELS; c++) begin
         grad_in.ch[c] = sfps_pkg::div_step(
            sfps_pkg::div_step(grad_src.ch[c], den, step_hi), den, step_hi - 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         grad_ff <= grad_in;
      end
   end

   assign grad_out = grad_ff;

endmodule

// ===== hdl/sfps_grad.sv =====
module sfps_grad (
   input  logic               clock,
   input  sfps_pkg::cfg_type  cfg,
   input  logic [4:1]         en,
   input  logic [14:0]        row,
   input  logic [14:0]        den,
   output sfps_pkg::grad_type grad
);

   // Stage B forms |bottom - top| * row per channel; stages C to E each take
   // two quotient bits of the division by height - 1.
   sfps_pkg::grad_type b_ff, b_in, c_out, d_out, e_out;

   always_comb begin
      logic [7:0] tc, bc, mag;
      b_in = '0;
      for (int c = 0; c < sfps_pkg::CHANNELS; c++) begin
         tc = cfg.fill_color[8*c +: 8];
         bc = cfg.second_color[8*c +: 8];
         b_in.neg[c] = bc < tc;
         mag = (bc < tc) ? (tc - bc) : (bc - tc);
         b_in.ch[c].rem = sfps_pkg::NUM_W'(mag) * sfps_pkg::NUM_W'(row);
         b_in.ch[c].quo = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         b_ff <= b_in;
      end
   end

   sfps_div_stage u_div_c (
      .clock(clock), .en(en[2]), .step_hi(3'd7), .den(den),
      .grad_src(b_ff), .grad_out(c_out)
   );

   sfps_div_stage u_div_d (
      .clock(clock), .en(en[3]), .step_hi(3'd5), .den(den),
      .grad_src(c_out), .grad_out(d_out)
   );

   sfps_div_stage u_div_e (
      .clock(clock), .en(en[4]), .step_hi(3'd3), .den(den),
      .grad_src(d_out), .grad_out(e_out)
   );

   assign grad = e_out;

endmodule

// ===== hdl/shape_fill_pixel_shader.sv =====
// Shape fill pixel shader: answers, for one in-frame pixel per beat, whether
// the configured shape (rounded rectangle, outline or vertical gradient box)
// covers it and with which ARGB color.
// The request channel req_bus carries pixel_x and pixel_y; the response
// channel rsp_bus returns covered and pixel_color, with pixel_color zero for
// an uncovered pixel. Registers are written through csr_bus (index, data),
// which is always ready; the user must change them only while no beat is in
// flight, since the block itself does not enforce this. The block is a
// six-stage pipeline, and one beat is taken every cycle while the response
// side keeps up. The rate is set by the single squared-distance compare and
// the four gradient divider lanes, which both advance one stage per cycle.
// Each stage holds its beat until the next one frees; an empty stage keeps
// accepting even while the output holds an unread beat, so a stalled
// receiver only fills the pipeline, and nothing is lost or repeated.
// A synchronous reset empties the pipeline and clears every configuration
// register to 0.
module shape_fill_pixel_shader #(
   parameter int MAX_FRAME_WIDTH  = 4096,
   parameter int MAX_FRAME_HEIGHT = 4096
) (
   input  logic       clock,
   input  logic       reset,
   sfps_req_if.sink   req_bus,
   sfps_rsp_if.source rsp_bus,
   sfps_csr_if.sink   csr_bus
);

   localparam logic [16:0] WIDTH_LIMIT  = 17'(MAX_FRAME_WIDTH);
   localparam logic [16:0] HEIGHT_LIMIT = 17'(MAX_FRAME_HEIGHT);
   localparam int STAGES = 6;

   sfps_pkg::cfg_type   cfg;
   sfps_pkg::shape_type shape;
   sfps_pkg::grad_type  grad;

   logic [STAGES-1:0] valid_ff, valid_in;
   logic [STAGES-1:0] en;
   logic              inframe;
   logic [14:0]       row;
   logic [14:0]       den;
   logic              den_zero;

   logic                           covered_ff, covered_in;
   logic [sfps_pkg::COLOR_W-1:0]   color_ff, color_in;

   sfps_cfg_regs u_cfg (
      .clock(clock), .reset(reset), .csr_bus(csr_bus), .cfg(cfg)
   );

   // A stage may load when it is empty or when the stage after it loads too.
   // The ready chain runs back from the response channel to the request side.
   always_comb begin
      logic nxt;
      nxt = rsp_bus.ready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         en[k] = !valid_ff[k] || nxt;
         nxt = en[k];
      end
   end

   always_comb begin
      for (int k = 0; k < STAGES; k++) begin
         if (en[k]) begin
            valid_in[k] = (k == 0) ? req_bus.valid : valid_ff[(k == 0) ? 0 : k - 1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_bus.ready = en[0];

   assign inframe = (17'(req_bus.pixel_x) < WIDTH_LIMIT)
                 && (17'(req_bus.pixel_y) < HEIGHT_LIMIT);

   // Coverage path: local coordinates, box and band tests, corner distance.
   sfps_geom u_geom (
      .clock(clock), .cfg(cfg), .en(en[4:0]),
      .pixel_x(req_bus.pixel_x), .pixel_y(req_bus.pixel_y), .inframe(inframe),
      .row(row), .shape(shape)
   );

   // Gradient path: channel differences scaled by row, divided by height - 1.
   // Inside the box the row never exceeds height - 1, so each quotient fits
   // in eight bits.
   assign den = cfg.rect_span_y - 15'd1;
   assign den_zero = (cfg.rect_span_y == 15'd1);

   sfps_grad u_grad (
      .clock(clock), .cfg(cfg), .en(en[4:1]), .row(row), .den(den), .grad(grad)
   );

   // Output stage: last two quotient bits, channel add or subtract, and the
   // choice by mode. A single-row gradient keeps the top color.
   always_comb begin
      sfps_pkg::div_type d;
      logic [7:0] tc;
      logic [sfps_pkg::COLOR_W-1:0] grad_color, color;
      logic cov;
      grad_color = '0;
      for (int c = 0; c < sfps_pkg::CHANNELS; c++) begin
         d = sfps_pkg::div_step(sfps_pkg::div_step(grad.ch[c], den, 3'd1), den, 3'd0);
         tc = cfg.fill_color[8*c +: 8];
         if (den_zero) begin
            grad_color[8*c +: 8] = tc;
         end else if (grad.neg[c]) begin
            grad_color[8*c +: 8] = tc - d.quo;
         end else begin
            grad_color[8*c +: 8] = tc + d.quo;
         end
      end
      case (cfg.fill_mode)
         sfps_pkg::MODE_ROUND: begin
            cov = shape.in_rect && shape.round_ok;
            color = cfg.fill_color;
         end
         sfps_pkg::MODE_OUTLINE: begin
            cov = shape.outl;
            color = cfg.fill_color;
         end
         sfps_pkg::MODE_GRADIENT: begin
            cov = shape.in_rect;
            color = grad_color;
         end
         default: begin
            cov = 1'b0;
            color = '0;
         end
      endcase
      covered_in = shape.ok && cov;
      color_in = covered_in ? color : '0;
   end

   always_ff @(posedge clock) begin
      if (en[STAGES-1]) begin
         covered_ff <= covered_in;
         color_ff <= color_in;
      end
   end

   assign rsp_bus.valid = valid_ff[STAGES-1];
   assign rsp_bus.covered = covered_ff;
   assign rsp_bus.pixel_color = color_ff;

endmodule
